// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Field widths of the stream payloads.
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int POS_OUT_W = 11;
  localparam int ATTR_W   = 8;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0a;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'h08;
  localparam logic [CHAR_W-1:0] BLANK_GLYPH    = 8'h20;

  // Attribute after reset, also used by the power-up screen fill.
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0f;

endpackage

// ===== src/tcce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/text_console_char_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text screen of attribute/glyph cells with a cursor, driven by a stream of
// put, read and clear commands.
// ----------------------------------------------------------------------------
// The engine keeps ROWS x COLS cells in one RAM and handles one command at a
// time; s_tready is high only while it is waiting for a command. A put of an
// ordinary character, a newline or a backspace and a read each go from their
// work state (S_PUT, S_READ) to S_RESP, since every cell access goes through
// the single RAM write port or its registered read port; an unused code goes
// straight to S_RESP. A put that moves the cursor past the last row adds a
// scroll (one read and one write per moved cell, then one write per blanked
// cell). A clear writes a blank to every cell and homes the cursor. After reset
// the engine fills the screen with blanks before it takes its first command;
// configuration writes are taken at all times. A finished result waits in the
// output register, and the next command may be taken while it waits.
module text_console_char_engine #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  // Command stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields from bit 0: char_code[7:0], cell_index[18:8], zero pad.
  input  logic [tcce_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser fields from bit 0: func[1:0].
  input  logic [tcce_pkg::FUNC_W-1:0]      s_tuser,
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata fields from bit 0: cell_data[15:0], cursor_row[20:16],
  // cursor_col[27:21], cursor_pos[38:28], zero pad.
  output logic [tcce_pkg::M_TDATA_W-1:0]   m_tdata,
  // Configuration write channel for the colour attribute.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcce_pkg::ATTR_W-1:0]      cfg_data
);

  localparam int CELL_COUNT    = ROWS * COLS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(COLS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_READ,
    S_CLEAR,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_RESP
  } state_t;

  state_t                         state;
  logic [ADDR_W-1:0]              sweep;
  logic [ROW_W-1:0]               cur_row;
  logic [COL_W-1:0]               cur_col;
  logic [ADDR_W-1:0]              cur_pos;
  logic [tcce_pkg::CHAR_W-1:0]    ch;
  logic [ADDR_W-1:0]              rd_addr;
  logic                           rd_hit;
  logic [tcce_pkg::ATTR_W-1:0]    color_attr;

  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_waddr;
  logic [tcce_pkg::CELL_W-1:0]    mem_wdata;
  logic                           mem_re;
  logic [ADDR_W-1:0]              mem_raddr;
  logic [tcce_pkg::CELL_W-1:0]    mem_rdata;

  logic [tcce_pkg::CELL_W-1:0]    blank_cell;
  logic                           sweep_last;
  logic [ADDR_W-1:0]              pos_delta;
  logic [ADDR_W-1:0]              pos_next;
  logic [COL_W-1:0]               col_next;
  logic                           row_step;
  logic                           need_scroll;
  logic [tcce_pkg::CHAR_W-1:0]    in_char;
  logic [tcce_pkg::INDEX_W-1:0]   in_index;
  logic [tcce_pkg::CELL_W-1:0]    resp_cell;

  assign in_char    = s_tdata[tcce_pkg::CHAR_W-1:0];
  assign in_index   = s_tdata[tcce_pkg::CHAR_W +: tcce_pkg::INDEX_W];
  assign blank_cell = {color_attr, tcce_pkg::BLANK_GLYPH};
  assign sweep_last = (sweep == ADDR_W'(CELL_COUNT - 1));
  assign s_tready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign resp_cell  = rd_hit ? mem_rdata : '0;

  // Cursor update of a put: one shared adder moves the linear position.
  always_comb begin
    col_next  = cur_col;
    row_step  = 1'b0;
    pos_delta = '0;
    if (ch == tcce_pkg::NEWLINE_CODE) begin
      col_next  = '0;
      row_step  = 1'b1;
      pos_delta = ADDR_W'(COLS) - ADDR_W'(cur_col);
    end else if (ch == tcce_pkg::BACKSPACE_CODE) begin
      if (cur_col != '0) begin
        col_next  = cur_col - 1'b1;
        pos_delta = '1;
      end
    end else begin
      pos_delta = ADDR_W'(1);
      if (cur_col == COL_W'(COLS - 1)) begin
        col_next = '0;
        row_step = 1'b1;
      end else begin
        col_next = cur_col + 1'b1;
      end
    end
    pos_next    = cur_pos + pos_delta;
    need_scroll = row_step && (cur_row == ROW_W'(ROWS - 1));
  end

  // RAM port control for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = sweep;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tcce_pkg::RESET_ATTR, tcce_pkg::BLANK_GLYPH};
      end
      S_CLEAR, S_BLANK: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_waddr = pos_next;
        if (ch == tcce_pkg::BACKSPACE_CODE) begin
          mem_we = (cur_col != '0);
        end else if (ch != tcce_pkg::NEWLINE_CODE) begin
          mem_we    = 1'b1;
          mem_waddr = cur_pos;
          mem_wdata = {color_attr, ch};
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = rd_addr;
      end
      S_SCR_RD: begin
        mem_re = 1'b1;
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep - ADDR_W'(COLS);
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  tcce_ram #(
    .WIDTH(tcce_pkg::CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Colour attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_attr <= tcce_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      color_attr <= cfg_data;
    end
  end

  // Sequencer, cursor and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sweep    <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      cur_pos  <= '0;
      rd_hit   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A result that leaves is dropped here unless the response state
      // loads the next one at the same edge.
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            ch      <= in_char;
            rd_addr <= ADDR_W'(in_index);
            rd_hit  <= 1'b0;
            sweep   <= '0;
            unique case (tcce_pkg::func_t'(s_tuser))
              tcce_pkg::FUNC_PUT:   state <= S_PUT;
              tcce_pkg::FUNC_READ: begin
                rd_hit <= (32'(in_index) < CELL_COUNT);
                state  <= S_READ;
              end
              tcce_pkg::FUNC_CLEAR: state <= S_CLEAR;
              default:              state <= S_RESP;
            endcase
          end
        end
        S_PUT: begin
          cur_col <= col_next;
          if (need_scroll) begin
            cur_pos <= ADDR_W'(LAST_ROW_BASE);
            sweep   <= ADDR_W'(COLS);
            state   <= S_SCR_RD;
          end else begin
            cur_pos <= pos_next;
            if (row_step) begin
              cur_row <= cur_row + 1'b1;
            end
            state <= S_RESP;
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep_last) begin
            cur_row <= '0;
            cur_col <= '0;
            cur_pos <= '0;
            state   <= S_RESP;
          end
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          if (sweep_last) begin
            sweep <= ADDR_W'(LAST_ROW_BASE);
            state <= S_BLANK;
          end else begin
            sweep <= sweep + 1'b1;
            state <= S_SCR_RD;
          end
        end
        S_BLANK: begin
          sweep <= sweep + 1'b1;
          if (sweep_last) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0,
                         tcce_pkg::POS_OUT_W'(cur_pos),
                         tcce_pkg::COL_OUT_W'(cur_col),
                         tcce_pkg::ROW_OUT_W'(cur_row),
                         resp_cell};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
